// ===== rtl/core/bff_pkg.sv =====
// Shared types, widths and operation codes of the flow-controlled byte FIFO.
package bff_pkg;

    // Fixed field widths
    localparam int FILL_W   = 13;
    localparam int TOT_W    = 48;
    localparam int BYTE_W   = 8;
    localparam int MODE_W   = 3;
    localparam int COUNT_W  = 7;

    // Parameter defaults and reset values
    localparam int DEPTH_DEF     = 4096;
    localparam int MAX_BURST_DEF = 64;
    localparam int CAP_RESET     = 4096;

    // Operation codes of the mode field
    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DISCARD = 3'd3;
    localparam logic [MODE_W-1:0] MODE_END     = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [BYTE_W-1:0]  data_byte;
        logic [COUNT_W-1:0] count;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              last;
        logic              accepted;
        logic [FILL_W-1:0] fill_level;
        logic [FILL_W-1:0] free_space;
        logic [TOT_W-1:0]  total_written;
        logic [TOT_W-1:0]  total_read;
        logic              input_done;
        logic              stream_eof;
    } t_out_item;

    // Sequencer to output stage: load strobe with the result
    typedef struct packed {
        logic      load;
        t_out_item item;
    } t_res_load;

endpackage

// ===== rtl/core/bff_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, and read port that holds its data when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bff_seq.sv =====
// Sequencer of the byte FIFO: pointers, counters and one step per cycle.
module bff_seq #(
    parameter int DEPTH     = bff_pkg::DEPTH_DEF,
    parameter int MAX_BURST = bff_pkg::MAX_BURST_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bff_pkg::t_in_item               i_in_item,
    input  logic [bff_pkg::FILL_W-1:0]      i_cap,
    input  logic                            i_slot_free,
    output bff_pkg::t_res_load              o_res,
    output logic                            o_ram_we,
    output logic [$clog2(DEPTH)-1:0]        o_ram_waddr,
    output logic [bff_pkg::BYTE_W-1:0]      o_ram_wdata,
    output logic                            o_ram_re,
    output logic [$clog2(DEPTH)-1:0]        o_ram_raddr,
    input  logic [bff_pkg::BYTE_W-1:0]      i_ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(MAX_BURST + 1);
    localparam int FW = bff_pkg::FILL_W;
    localparam int TW = bff_pkg::TOT_W;
    localparam int NW = bff_pkg::COUNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STAT = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [1:0] S_DISC = 2'd3;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
        adv = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    logic [1:0]                  r_state, n_state;
    logic [bff_pkg::MODE_W-1:0]  r_mode, n_mode;
    logic [bff_pkg::BYTE_W-1:0]  r_data, n_data;
    logic [CW-1:0]               r_left, n_left;
    logic [AW-1:0]               r_pos, n_pos;
    logic [AW-1:0]               r_head, n_head;
    logic [AW-1:0]               r_tail, n_tail;
    logic [FW-1:0]               r_held, n_held;
    logic [TW-1:0]               r_wtot, n_wtot;
    logic [TW-1:0]               r_rtot, n_rtot;
    logic                        r_ended, n_ended;

    logic                        in_take;
    logic [NW-1:0]               cnt_clamped;
    logic [FW-1:0]               burst;
    logic                        burst_zero;
    logic                        write_ok;
    logic [bff_pkg::BYTE_W-1:0]  res_byte;
    logic                        res_has;
    logic                        res_last;
    logic                        res_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_take    = i_in_valid && o_in_ready;

    // Clamp the requested count to the burst limit and the bytes held
    always_comb begin
        cnt_clamped = (i_in_item.count > NW'(MAX_BURST))
                      ? NW'(MAX_BURST) : i_in_item.count;
        burst = ({{(FW - NW){1'b0}}, cnt_clamped} > r_held)
                ? r_held : {{(FW - NW){1'b0}}, cnt_clamped};
        burst_zero = (burst == '0);
    end

    assign write_ok = (r_held < i_cap);

    // Step the sequencer
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_data  = r_data;
        n_left  = r_left;
        n_pos   = r_pos;
        n_head  = r_head;
        n_tail  = r_tail;
        n_held  = r_held;
        n_wtot  = r_wtot;
        n_rtot  = r_rtot;
        n_ended = r_ended;

        o_ram_we    = 1'b0;
        o_ram_waddr = r_tail;
        o_ram_wdata = r_data;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_head;

        o_res.load = 1'b0;
        res_byte   = '0;
        res_has    = 1'b0;
        res_last   = 1'b1;
        res_acc    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_mode = i_in_item.mode;
                    n_data = i_in_item.data_byte;
                    n_left = burst[CW-1:0];
                    unique case (i_in_item.mode)
                        bff_pkg::MODE_READ, bff_pkg::MODE_PEEK: begin
                            if (burst_zero) begin
                                n_state = S_STAT;
                            end else begin
                                // fetch the first byte at the head
                                o_ram_re    = 1'b1;
                                o_ram_raddr = r_head;
                                n_pos       = adv(r_head);
                                n_state     = S_EMIT;
                            end
                        end
                        bff_pkg::MODE_DISCARD: begin
                            n_state = burst_zero ? S_STAT : S_DISC;
                        end
                        bff_pkg::MODE_END: begin
                            n_ended = 1'b1;
                            n_state = S_STAT;
                        end
                        default: begin
                            n_state = S_STAT;
                        end
                    endcase
                end
            end
            S_STAT: begin
                // single status result, storing the byte on a write that fits the capacity
                if (i_slot_free) begin
                    o_res.load = 1'b1;
                    if (r_mode == bff_pkg::MODE_WRITE && write_ok) begin
                        res_acc  = 1'b1;
                        o_ram_we = 1'b1;
                        n_tail   = adv(r_tail);
                        n_held   = r_held + FW'(1);
                        n_wtot   = r_wtot + TW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                // hand out one byte, prefetch the next
                if (i_slot_free) begin
                    o_res.load = 1'b1;
                    res_byte   = i_ram_rdata;
                    res_has    = 1'b1;
                    res_last   = (r_left == CW'(1));
                    n_left     = r_left - CW'(1);
                    if (r_mode == bff_pkg::MODE_READ) begin
                        n_head = r_pos;
                        n_held = r_held - FW'(1);
                        n_rtot = r_rtot + TW'(1);
                    end
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = r_pos;
                        n_pos       = adv(r_pos);
                    end
                end
            end
            S_DISC: begin
                // drop one byte per cycle
                n_head = adv(r_head);
                n_held = r_held - FW'(1);
                n_rtot = r_rtot + TW'(1);
                n_left = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = S_STAT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Status snapshot after this step
        o_res.item.out_byte      = res_byte;
        o_res.item.has_byte      = res_has;
        o_res.item.last          = res_last;
        o_res.item.accepted      = res_acc;
        o_res.item.fill_level    = n_held;
        o_res.item.free_space    = (n_held >= i_cap) ? '0 : i_cap - n_held;
        o_res.item.total_written = n_wtot;
        o_res.item.total_read    = n_rtot;
        o_res.item.input_done    = r_ended;
        o_res.item.stream_eof    = r_ended && (n_held == '0);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_held  <= '0;
            r_wtot  <= '0;
            r_rtot  <= '0;
            r_ended <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_held  <= n_held;
            r_wtot  <= n_wtot;
            r_rtot  <= n_rtot;
            r_ended <= n_ended;
        end
    end

    // Transaction payload
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_data <= n_data;
        r_left <= n_left;
        r_pos  <= n_pos;
    end

endmodule

// ===== rtl/core/flow_controlled_byte_fifo.sv =====
// Top level of the flow-controlled byte FIFO: capacity register and output stage.
//
// Usage: items arrive on the input channel (i_in_valid / o_in_ready, i_in_item)
// and results leave on the output channel (o_out_valid / i_out_ready,
// o_out_item). A write, end-of-input, discard or unused mode yields one
// status result; a read or peek of n bytes (n clamped to MAX_BURST and the
// fill level) yields n results, one byte each, with last set on the final
// one, or one status result when n is zero. The capacity register is written
// over the cfg channel (always ready); the user must write it only while no
// transaction is in flight, which the block itself does not enforce. A burst
// streams one byte per cycle, while the receiver takes each result, once the
// first memory read returns; a discard steps the head pointer once per cycle,
// then yields its status result. Input is taken again once the last result
// of the item sits in the output register. Reset clears pointers, fill level,
// totals and the end flag, and sets the capacity to 4096 bounded by DEPTH;
// the byte store itself is not cleared. When the receiver stalls the output
// register holds its result and the sequencer waits, losing nothing.
module flow_controlled_byte_fifo #(
    parameter int DEPTH     = bff_pkg::DEPTH_DEF,
    parameter int MAX_BURST = bff_pkg::MAX_BURST_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bff_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bff_pkg::t_out_item           o_out_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bff_pkg::FILL_W-1:0]   i_cfg_data
);

    localparam int AW       = $clog2(DEPTH);
    localparam int FW       = bff_pkg::FILL_W;
    localparam int CAP_INIT = (bff_pkg::CAP_RESET > DEPTH) ? DEPTH : bff_pkg::CAP_RESET;

    logic [FW-1:0]              r_cap;
    logic                       r_out_valid;
    bff_pkg::t_out_item         r_out;
    logic                       slot_free;
    bff_pkg::t_res_load         res;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [bff_pkg::BYTE_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [bff_pkg::BYTE_W-1:0] ram_rdata;

    assign o_cfg_ready = 1'b1;

    // Hold the capacity in effect, bounded by the store depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= FW'(CAP_INIT);
        end else if (i_cfg_valid) begin
            r_cap <= ({19'd0, i_cfg_data} > 32'(DEPTH)) ? FW'(DEPTH) : i_cfg_data;
        end
    end

    assign slot_free = !r_out_valid || i_out_ready;

    // Output register: load a new result or drop the one taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_out <= res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    bff_seq #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_cap       (r_cap),
        .i_slot_free (slot_free),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    bff_ram #(
        .WIDTH (bff_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
